// ===== sv/mrcd_pkg.sv =====
// Shared types and constants for the mixed-run cluster detector.
// No dependencies; imported by every module of the block.
package mrcd_pkg;

  localparam int LCP_WIDTH      = 16;
  localparam int DOC_WIDTH      = 32;
  localparam int POSITION_WIDTH = 40;
  localparam int CFG_WIDTH      = (DOC_WIDTH > LCP_WIDTH) ? DOC_WIDTH : LCP_WIDTH;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [LCP_WIDTH-1:0]      lcp_t;
  typedef logic [DOC_WIDTH-1:0]      doc_t;
  typedef logic [POSITION_WIDTH-1:0] pos_t;

  typedef enum logic {
    REG_ALPHA     = 1'b0,
    REG_NUM_READS = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_CLUSTER = 1'b0,
    KIND_SUMMARY = 1'b1
  } res_kind_t;

  typedef struct packed {
    lcp_t prefix_len;
    doc_t doc_id;
    logic last;
  } item_word_t;

  typedef struct packed {
    logic kind;
    pos_t cluster_start;
    pos_t cluster_len;
    pos_t longest;
    pos_t cluster_count;
    logic final_res;
  } res_word_t;

  typedef struct packed {
    lcp_t alpha;
    doc_t num_reads;
  } cfg_t;

  // words produced by one item, first word is w0
  typedef struct packed {
    logic [1:0] n;
    res_word_t  w0;
    res_word_t  w1;
  } push_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == POS_MAX) ? POS_MAX : v + pos_t'(1);
  endfunction

endpackage

// ===== sv/mrcd_step.sv =====
// Per-item run tracking: stream state registers and their combinational next-state update.
// Depends on mrcd_pkg.
module mrcd_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  mrcd_pkg::item_word_t item,
  input  mrcd_pkg::cfg_t      cfg,
  output mrcd_pkg::push_t     push
);
  import mrcd_pkg::*;

  doc_t prev_doc, prev_doc_next;
  pos_t position, position_next;
  pos_t pos_m1, pos_m1_next;
  logic run_open, run_open_next;
  logic read_seen, read_seen_next;
  logic genome_seen, genome_seen_next;
  pos_t run_start, run_start_next;
  pos_t longest_len, longest_len_next;
  pos_t total_clusters, total_clusters_next;

  logic keep, brk, opening, prev_rd, cur_rd;
  logic open1, rd1, gn1, emit;
  pos_t start1, end_pos, len;
  res_word_t clus_w, summ_w;

  always_comb begin
    keep    = (position != '0) && (item.prefix_len >= cfg.alpha);
    brk     = (position != '0) && !keep;
    opening = keep && !run_open;
    prev_rd = prev_doc < cfg.num_reads;
    cur_rd  = item.doc_id < cfg.num_reads;

    open1  = run_open | keep;
    start1 = opening ? pos_m1 : run_start;
    rd1    = read_seen | (opening & prev_rd) | (keep & cur_rd);
    gn1    = genome_seen | (opening & !prev_rd) | (keep & !cur_rd);

    position_next = sat_inc(position);
    pos_m1_next   = (position == POS_MAX) ? POS_MAX - pos_t'(1) : position;

    // at most one run closes per item: a break clears before the end-of-stream close
    emit    = (brk | item.last) & open1 & rd1 & gn1;
    end_pos = brk ? position : position_next;
    len     = end_pos - start1;

    longest_len_next    = (emit && (longest_len < len)) ? len : longest_len;
    total_clusters_next = emit ? sat_inc(total_clusters) : total_clusters;

    clus_w.kind          = KIND_CLUSTER;
    clus_w.cluster_start = start1;
    clus_w.cluster_len   = len;
    clus_w.longest       = longest_len_next;
    clus_w.cluster_count = total_clusters_next;
    clus_w.final_res     = !item.last;

    summ_w.kind          = KIND_SUMMARY;
    summ_w.cluster_start = '0;
    summ_w.cluster_len   = '0;
    summ_w.longest       = longest_len_next;
    summ_w.cluster_count = total_clusters_next;
    summ_w.final_res     = 1'b1;

    push.n  = {1'b0, emit} + {1'b0, item.last};
    push.w0 = emit ? clus_w : summ_w;
    push.w1 = summ_w;

    prev_doc_next    = item.doc_id;
    run_open_next    = open1 & !brk;
    read_seen_next   = rd1 & !brk;
    genome_seen_next = gn1 & !brk;
    run_start_next   = brk ? '0 : start1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_doc       <= '0;
      position       <= '0;
      pos_m1         <= '0;
      run_open       <= 1'b0;
      read_seen      <= 1'b0;
      genome_seen    <= 1'b0;
      run_start      <= '0;
      longest_len    <= '0;
      total_clusters <= '0;
    end else if (acc) begin
      if (item.last) begin
        prev_doc       <= '0;
        position       <= '0;
        pos_m1         <= '0;
        run_open       <= 1'b0;
        read_seen      <= 1'b0;
        genome_seen    <= 1'b0;
        run_start      <= '0;
        longest_len    <= '0;
        total_clusters <= '0;
      end else begin
        prev_doc       <= prev_doc_next;
        position       <= position_next;
        pos_m1         <= pos_m1_next;
        run_open       <= run_open_next;
        read_seen      <= read_seen_next;
        genome_seen    <= genome_seen_next;
        run_start      <= run_start_next;
        longest_len    <= longest_len_next;
        total_clusters <= total_clusters_next;
      end
    end
  end

endmodule

// ===== sv/mrcd_outq.sv =====
// Result queue: takes up to two words a cycle, hands out one while res_stall is low.
// Depends on mrcd_pkg.
module mrcd_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  mrcd_pkg::push_t     push,
  output logic                full,
  output logic                res_valid,
  input  logic                res_stall,
  output mrcd_pkg::res_word_t res
);
  import mrcd_pkg::*;

  res_word_t          mem [QDEPTH];
  logic [QPTR_W-1:0]  head, tail;
  logic [QCNT_W-1:0]  count, count_next;
  logic [1:0]         n_in;
  logic               pop;

  assign n_in      = wr ? push.n : 2'd0;
  assign pop       = res_valid && !res_stall;
  assign res_valid = count != '0;
  assign res       = mem[head];
  // room for the two words one item may cause
  assign full      = count > QCNT_W'(QDEPTH - 2);

  always_comb begin
    count_next = count + QCNT_W'(n_in) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QPTR_W'(pop);
      tail  <= tail + QPTR_W'(n_in);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem[tail] <= push.w0;
    if (n_in == 2'd2) mem[tail + QPTR_W'(1)] <= push.w1;
  end

endmodule

// ===== sv/mixed_run_cluster_detector_core.sv =====
// Mixed-run cluster detector: top level with configuration registers.
// Depends on mrcd_pkg, mrcd_step and mrcd_outq.
//
// Takes one (prefix length, document id) word per clock while not stalled and emits a word
// for each run of suffixes holding both a read and a genome, plus a summary after the word
// marked last. The stream state is updated in the cycle a word is taken; results
// wait in a four-word queue, so input is stalled only when fewer than two queue
// slots are free. Sustained input rate is one word per cycle while the output side
// keeps up; an item causes at most two result words and the output drains one per
// cycle when res_stall is low.
module mixed_run_cluster_detector_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  mrcd_pkg::item_word_t item,
  output logic                 res_valid,
  input  logic                 res_stall,
  output mrcd_pkg::res_word_t  res,
  input  logic                 cfg_we,
  input  mrcd_pkg::reg_index_t cfg_index,
  input  logic [mrcd_pkg::CFG_WIDTH-1:0] cfg_data
);
  import mrcd_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  full, acc;

  assign item_stall = full;
  assign acc        = item_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha     <= lcp_t'(16);
      cfg.num_reads <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA:     cfg.alpha     <= cfg_data[LCP_WIDTH-1:0];
        REG_NUM_READS: cfg.num_reads <= cfg_data[DOC_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  mrcd_step u_step (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .item (item),
    .cfg  (cfg),
    .push (push)
  );

  mrcd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr        (acc),
    .push      (push),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
